// ===== sv/rbwl_pkg.sv =====
package rbwl_pkg;

    // Operand width of the numerator and denominator: 4*raw minus the sum of
    // four black levels spans about +/-2^18, which fits a 19-bit signed value.
    localparam int OPD_W = 19;
    // Magnitude width of either operand once it is known to be positive.
    localparam int MAG_W = OPD_W - 1;
    // Width of the normalized result (signed Q3.16 at the default fraction).
    localparam int OUT_W = 20;
    // Saturation bounds, as magnitudes of the positive and negative limits.
    localparam int OUT_POS_MAX = 524287;
    localparam int OUT_NEG_MAX = 524288;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_BLACK_A     = 3'd0;
    localparam logic [2:0] CFG_BLACK_B     = 3'd1;
    localparam logic [2:0] CFG_BLACK_C     = 3'd2;
    localparam logic [2:0] CFG_BLACK_D     = 3'd3;
    localparam logic [2:0] CFG_WHITE       = 3'd4;
    localparam logic [2:0] CFG_CROP_PHASE  = 3'd5;
    localparam logic [2:0] CFG_LINE_WIDTH  = 3'd6;
    localparam logic [2:0] CFG_MOSAIC_MODE = 3'd7;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SAT     = 2'd1,
        ST_BAD_DEN = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        logic [3:0][15:0] black;
        logic [15:0]      white;
        logic [1:0]       crop_phase;
        logic [13:0]      line_width;
        logic             mosaic_mode;
    } t_cfg;

    typedef struct packed {
        logic signed [OPD_W-1:0] num;
        logic signed [OPD_W-1:0] den;
    } t_job;

endpackage

// ===== sv/rbwl_front.sv =====
module rbwl_front #(
    parameter int MAX_LINE_WIDTH = 8192
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rbwl_pkg::t_cfg i_cfg,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic [15:0]    i_raw_pixel,
    input  logic           i_frame_start,
    output logic           o_job_valid,
    input  logic           i_job_ready,
    output rbwl_pkg::t_job o_job
);
    import rbwl_pkg::*;

    localparam int CNT_W = $clog2(MAX_LINE_WIDTH);
    localparam int CMP_W = (CNT_W + 1 > 14) ? CNT_W + 1 : 14;

    logic [CNT_W-1:0] r_col, n_col;
    logic             r_row, n_row;

    logic [CNT_W-1:0] col_cur;
    logic             row_cur;
    logic [1:0]       idx;
    logic [15:0]      blk;
    logic [17:0]      sum;
    logic [CMP_W-1:0] next_col;
    logic [CMP_W-1:0] lw_ext;
    logic [CMP_W-1:0] eff_width;
    logic             accept;

    assign accept      = i_s_tvalid && i_job_ready;
    assign o_s_tready  = i_job_ready;
    assign o_job_valid = i_s_tvalid;

    always_comb begin
        // Restart the mosaic position on the first pixel of a frame.
        col_cur = i_frame_start ? '0 : r_col;
        row_cur = i_frame_start ? 1'b0 : r_row;
        idx     = {row_cur ^ i_cfg.crop_phase[1], col_cur[0] ^ i_cfg.crop_phase[0]};
        blk     = i_cfg.black[idx];
        sum     = {2'b00, i_cfg.black[0]} + {2'b00, i_cfg.black[1]}
                + {2'b00, i_cfg.black[2]} + {2'b00, i_cfg.black[3]};

        if (i_cfg.mosaic_mode) begin
            o_job.num = $signed({3'b000, i_raw_pixel}) - $signed({3'b000, blk});
            o_job.den = $signed({3'b000, i_cfg.white}) - $signed({3'b000, blk});
        end else begin
            o_job.num = $signed({1'b0, i_raw_pixel, 2'b00}) - $signed({1'b0, sum});
            o_job.den = $signed({1'b0, i_cfg.white, 2'b00}) - $signed({1'b0, sum});
        end

        lw_ext    = CMP_W'(i_cfg.line_width);
        eff_width = (lw_ext == '0 || lw_ext > CMP_W'(MAX_LINE_WIDTH))
                  ? CMP_W'(MAX_LINE_WIDTH) : lw_ext;
        next_col  = CMP_W'(col_cur) + CMP_W'(1);

        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (next_col >= eff_width) begin
                n_col = '0;
                n_row = ~row_cur;
            end else begin
                n_col = next_col[CNT_W-1:0];
                n_row = row_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== sv/rbwl_queue.sv =====
module rbwl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  rbwl_pkg::t_job i_push_job,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output rbwl_pkg::t_job o_pop_job
);
    import rbwl_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_job             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CNT_W'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

// ===== sv/rbwl_back.sv =====
module rbwl_back #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    output logic                       o_job_ready,
    input  rbwl_pkg::t_job             i_job,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [rbwl_pkg::OUT_W-1:0] o_m_pixel,
    output rbwl_pkg::t_status          o_m_status
);
    import rbwl_pkg::*;

    localparam int DVD_W = MAG_W + FRACTION_BITS;
    localparam int ITR_W = $clog2(DVD_W);

    t_back_state r_state, n_state;

    logic [DVD_W-1:0] r_quo, n_quo;
    logic [MAG_W-1:0] r_rem, n_rem;
    logic [MAG_W-1:0] r_den, n_den;
    logic [ITR_W-1:0] r_itr, n_itr;
    logic             r_neg, n_neg;
    logic             r_bad, n_bad;

    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out_pixel, n_out_pixel;
    t_status          r_out_status, n_out_status;

    logic             load, step, emit;
    logic [OPD_W-1:0] num_abs;
    logic [MAG_W:0]   trial;
    logic [MAG_W:0]   trial_sub;
    logic             ge;
    logic [OUT_W-1:0] res_pixel;
    t_status          res_status;

    always_comb begin
        n_state     = r_state;
        o_job_ready = 1'b0;
        load        = 1'b0;
        step        = 1'b0;
        emit        = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    o_job_ready = 1'b1;
                    load        = 1'b1;
                    n_state     = (i_job.den <= 0) ? BK_DONE : BK_DIV;
                end
            end
            BK_DIV: begin
                step = 1'b1;
                if (r_itr == ITR_W'(DVD_W - 1)) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    emit    = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        num_abs   = i_job.num[OPD_W-1] ? -i_job.num : i_job.num;
        trial     = {r_rem, r_quo[DVD_W-1]};
        trial_sub = trial - {1'b0, r_den};
        ge        = (trial >= {1'b0, r_den});

        n_quo = r_quo;
        n_rem = r_rem;
        n_den = r_den;
        n_itr = r_itr;
        n_neg = r_neg;
        n_bad = r_bad;
        if (load) begin
            n_quo = {num_abs[MAG_W-1:0], {FRACTION_BITS{1'b0}}};
            n_rem = '0;
            n_den = i_job.den[MAG_W-1:0];
            n_itr = '0;
            n_neg = i_job.num[OPD_W-1];
            n_bad = (i_job.den <= 0);
        end else if (step) begin
            // Shift in one dividend bit, subtract where it fits.
            n_rem = ge ? trial_sub[MAG_W-1:0] : trial[MAG_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], ge};
            n_itr = r_itr + ITR_W'(1);
        end

        if (r_bad) begin
            res_pixel  = '0;
            res_status = ST_BAD_DEN;
        end else if (!r_neg && r_quo > DVD_W'(OUT_POS_MAX)) begin
            res_pixel  = OUT_W'(OUT_POS_MAX);
            res_status = ST_SAT;
        end else if (r_neg && r_quo > DVD_W'(OUT_NEG_MAX)) begin
            res_pixel  = -OUT_W'(OUT_NEG_MAX);
            res_status = ST_SAT;
        end else begin
            res_pixel  = r_neg ? -r_quo[OUT_W-1:0] : r_quo[OUT_W-1:0];
            res_status = ST_OK;
        end

        n_out_valid  = r_out_valid;
        n_out_pixel  = r_out_pixel;
        n_out_status = r_out_status;
        if (o_m_tvalid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (emit) begin
            n_out_valid  = 1'b1;
            n_out_pixel  = res_pixel;
            n_out_status = res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_den        <= n_den;
        r_itr        <= n_itr;
        r_neg        <= n_neg;
        r_bad        <= n_bad;
        r_out_pixel  <= n_out_pixel;
        r_out_status <= n_out_status;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_pixel  = r_out_pixel;
    assign o_m_status = r_out_status;

endmodule

// ===== sv/raw_black_white_level_normalizer_core.sv =====
// Raw black/white level normalizer: takes 16-bit raw pixels in raster order
// and returns (raw - black) / (white - black) as a signed fixed-point value
// with FRACTION_BITS fraction bits (Q3.16 by default), truncated toward zero
// and saturated to 20 bits, plus a status code (ok, saturated, or white not
// above black, which gives zero). In mosaic mode the black level follows the
// 2x2 position of the pixel, shifted by the crop phase; otherwise the exact
// mean of the four levels is used. The front tracks column and row parity,
// resets them on a pixel flagged as frame start, and forms numerator and
// denominator in the cycle the pixel is accepted; a two-item queue then feeds
// a restoring divider that produces one quotient bit per cycle. The back loads
// an item, runs the divider steps unless white does not exceed black, and
// writes the result once the output register is free; it takes a new item
// only after emitting the last, so the divider loop sets the sustained rate.
// Up to two pixels queue ahead of the divider and one finished result waits
// in the output register. Configure through the write port only while idle.
module raw_black_white_level_normalizer_core #(
    parameter int MAX_LINE_WIDTH = 8192,
    parameter int FRACTION_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] raw_pixel
    input  logic        s_axis_tuser,   // [0] frame_start

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [19:0] normalized_pixel, [23:20] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import rbwl_pkg::*;

    t_cfg             r_cfg, n_cfg;
    t_job             front_job, queue_job;
    logic             front_valid, queue_ready;
    logic             queue_valid, back_ready;
    logic [OUT_W-1:0] out_pixel;
    t_status          out_status;

    // Decode register writes; ignore nothing here since every index is used.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BLACK_A:     n_cfg.black[0]    = i_cfg_data;
                CFG_BLACK_B:     n_cfg.black[1]    = i_cfg_data;
                CFG_BLACK_C:     n_cfg.black[2]    = i_cfg_data;
                CFG_BLACK_D:     n_cfg.black[3]    = i_cfg_data;
                CFG_WHITE:       n_cfg.white       = i_cfg_data;
                CFG_CROP_PHASE:  n_cfg.crop_phase  = i_cfg_data[1:0];
                CFG_LINE_WIDTH:  n_cfg.line_width  = i_cfg_data[13:0];
                CFG_MOSAIC_MODE: n_cfg.mosaic_mode = i_cfg_data[0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.black       <= '0;
            r_cfg.white       <= 16'hFFFF;
            r_cfg.crop_phase  <= 2'd0;
            r_cfg.line_width  <= 14'd8192;
            r_cfg.mosaic_mode <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Classify the pixel by mosaic position and form the division operands.
    rbwl_front #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_s_tvalid   (s_axis_tvalid),
        .o_s_tready   (s_axis_tready),
        .i_raw_pixel  (s_axis_tdata),
        .i_frame_start(s_axis_tuser),
        .o_job_valid  (front_valid),
        .i_job_ready  (queue_ready),
        .o_job        (front_job)
    );

    // Hold operands while the divider works on an earlier item.
    rbwl_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(front_valid),
        .o_push_ready(queue_ready),
        .i_push_job  (front_job),
        .o_pop_valid (queue_valid),
        .i_pop_ready (back_ready),
        .o_pop_job   (queue_job)
    );

    // Divide, saturate and register the result.
    rbwl_back #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(queue_valid),
        .o_job_ready(back_ready),
        .i_job      (queue_job),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_pixel  (out_pixel),
        .o_m_status (out_status)
    );

    assign m_axis_tdata = {4'b0000, out_pixel};
    assign m_axis_tuser = out_status;

endmodule

// ===== tb/rbwl_norm_checker.sv =====
module rbwl_norm_checker #(
    parameter int MAX_LINE_WIDTH = 8192,
    parameter int FRACTION_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] raw_pixel
    input  logic        s_axis_tuser,   // [0] frame_start

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [19:0] normalized_pixel, [23:20] zero
    input  logic [1:0]  m_axis_tuser,   // [1:0] status

    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rbwl_pkg::*;

    typedef struct {
        logic signed [OUT_W-1:0] pixel;
        t_status                 status;
    } t_norm_pixel;

    // Shadow copy of the level registers, updated from the write port.
    logic [15:0] black_lvl [4];
    logic [15:0] white_lvl;
    logic [1:0]  crop;
    logic [13:0] line_w;
    logic        mosaic;

    // Raster position of the next pixel.
    int          col_pos;
    logic        row_par;

    t_norm_pixel expected_pixels [$];
    int          mismatches  = 0;
    int          outstanding = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = outstanding;

    // Normalize one pixel against the current levels and advance the position.
    function automatic t_norm_pixel normalize_pixel(input logic [15:0] raw, input logic first);
        t_norm_pixel res;
        int          pos;
        int          width;
        longint      blk_sum;
        longint      num;
        longint      den;
        longint      quo;
        if (first) begin
            col_pos = 0;
            row_par = 1'b0;
        end
        pos = ((col_pos & 1) ^ crop[0]) + 2 * (row_par ^ crop[1]);
        if (mosaic) begin
            num = longint'(raw) - longint'(black_lvl[pos]);
            den = longint'(white_lvl) - longint'(black_lvl[pos]);
        end else begin
            // Exact mean: scale both terms by four instead of dividing the sum.
            blk_sum = longint'(black_lvl[0]) + longint'(black_lvl[1])
                    + longint'(black_lvl[2]) + longint'(black_lvl[3]);
            num = 4 * longint'(raw) - blk_sum;
            den = 4 * longint'(white_lvl) - blk_sum;
        end
        res.status = ST_OK;
        if (den <= 0) begin
            res.pixel  = '0;
            res.status = ST_BAD_DEN;
        end else begin
            quo = (num * (64'sd1 <<< FRACTION_BITS)) / den;
            if (quo > OUT_POS_MAX) begin
                quo        = OUT_POS_MAX;
                res.status = ST_SAT;
            end else if (quo < -longint'(OUT_NEG_MAX)) begin
                quo        = -longint'(OUT_NEG_MAX);
                res.status = ST_SAT;
            end
            res.pixel = quo[OUT_W-1:0];
        end
        width = (line_w == 0 || line_w > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : int'(line_w);
        if (col_pos + 1 >= width) begin
            col_pos = 0;
            row_par = ~row_par;
        end else begin
            col_pos = col_pos + 1;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_norm_pixel want;
        if (!i_rst_n) begin
            black_lvl = '{default: 16'd0};
            white_lvl = 16'hFFFF;
            crop      = 2'd0;
            line_w    = 14'd8192;
            mosaic    = 1'b1;
            col_pos   = 0;
            row_par   = 1'b0;
            expected_pixels.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected item: normalized_pixel %0d status %0d",
                           $signed(m_axis_tdata[OUT_W-1:0]), m_axis_tuser);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_axis_tdata[OUT_W-1:0] !== want.pixel) begin
                        $error("normalized_pixel mismatch: expected %0d, actual %0d",
                               want.pixel, $signed(m_axis_tdata[OUT_W-1:0]));
                        mismatches++;
                    end
                    if (m_axis_tuser !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_axis_tuser);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_pixels.push_back(normalize_pixel(s_axis_tdata, s_axis_tuser));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BLACK_A:     black_lvl[0] = i_cfg_data;
                    CFG_BLACK_B:     black_lvl[1] = i_cfg_data;
                    CFG_BLACK_C:     black_lvl[2] = i_cfg_data;
                    CFG_BLACK_D:     black_lvl[3] = i_cfg_data;
                    CFG_WHITE:       white_lvl    = i_cfg_data;
                    CFG_CROP_PHASE:  crop         = i_cfg_data[1:0];
                    CFG_LINE_WIDTH:  line_w       = i_cfg_data[13:0];
                    CFG_MOSAIC_MODE: mosaic       = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        outstanding = expected_pixels.size();
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rbwl_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int LONG_HOLD     = 400;   // receiver hold-off that backs up the queue
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 117;
    localparam int TAIL_CYCLES   = 80;    // idle tail before the final verdict

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [2:0]  i_cfg_index   = CFG_BLACK_A;
    logic [15:0] i_cfg_data    = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = 16'd0;   // [15:0] raw_pixel
    logic        s_axis_tuser  = 1'b0;    // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;            // [19:0] normalized_pixel, [23:20] zero
    logic [1:0]  m_axis_tuser;            // [1:0] status

    int          fail_count;
    int          pending;

    // Idle rates in percent; the receiver process reads its own rate.
    int          tx_idle_pct   = 24;
    int          rx_idle_pct   = 62;
    // Bump to request one long receiver hold-off.
    int          hold_request  = 0;

    t_cfg        cur_cfg;

    always #10 i_clk = ~i_clk;

    raw_black_white_level_normalizer_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    rbwl_norm_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Receiver: drop tready at random, or hold it low for a long stretch on request.
    always @(negedge i_clk) begin : receiver
        static int hold_left = 0;
        static int hold_seen = 0;
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_left = LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: report failure and end the run if it has not finished by the cycle limit.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("raw_black_white_level_normalizer_core verification failed");
        $finish;
    end

    // Offer one pixel, idling first at the current rate; return at the falling
    // edge after the item is taken, with tvalid still high.
    task automatic push_pixel(input logic [15:0] raw, input logic first);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        s_axis_tuser  <= first;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every result is out, then let the block settle.
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Hold the write enable high across consecutive writes; program_levels lowers it.
    task automatic cfg_write(input logic [2:0] index, input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(negedge i_clk);
    endtask

    task automatic program_levels(input t_cfg c);
        cfg_write(CFG_BLACK_A, c.black[0]);
        cfg_write(CFG_BLACK_B, c.black[1]);
        cfg_write(CFG_BLACK_C, c.black[2]);
        cfg_write(CFG_BLACK_D, c.black[3]);
        cfg_write(CFG_WHITE, c.white);
        cfg_write(CFG_CROP_PHASE, {14'd0, c.crop_phase});
        cfg_write(CFG_LINE_WIDTH, {2'd0, c.line_width});
        cfg_write(CFG_MOSAIC_MODE, {15'd0, c.mosaic_mode});
        i_cfg_we <= 1'b0;
        cur_cfg = c;
    endtask

    // Draw a level setting: mostly black well under white and short lines so
    // rows toggle often, with out-of-range widths and inverted levels mixed in.
    function automatic t_cfg random_levels();
        t_cfg c;
        case ($urandom_range(7))
            0:       c.white = 16'hFFFF;
            1:       c.white = 16'd4095;
            2:       c.white = 16'd1023;
            3:       c.white = 16'd0;
            default: c.white = 16'($urandom_range(65535, 256));
        endcase
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(9))
                0:       c.black[k] = 16'd0;
                1:       c.black[k] = c.white;
                2:       c.black[k] = 16'($urandom_range(65535));
                default: c.black[k] = 16'($urandom_range(c.white >> 3));
            endcase
        end
        case ($urandom_range(9))
            0:       c.line_width = 14'd1;
            1:       c.line_width = 14'd2;
            2:       c.line_width = 14'd0;
            3:       c.line_width = 14'($urandom_range(16383, 8193));
            4:       c.line_width = 14'd8192;
            default: c.line_width = 14'($urandom_range(64, 3));
        endcase
        c.crop_phase  = 2'($urandom_range(3));
        c.mosaic_mode = ($urandom_range(3) != 0);
        return c;
    endfunction

    initial begin : stimulus
        logic [15:0] raw;
        logic        first;

        cur_cfg.black       = '0;
        cur_cfg.white       = 16'hFFFF;
        cur_cfg.crop_phase  = 2'd0;
        cur_cfg.line_width  = 14'd8192;
        cur_cfg.mosaic_mode = 1'b1;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset levels: zero, full scale (exactly 1.0), smallest step, midscale.
        push_pixel(16'd0, 1'b1);
        push_pixel(16'hFFFF, 1'b0);
        push_pixel(16'd1, 1'b0);
        push_pixel(16'h8000, 1'b0);
        drain_block();

        // One black per mosaic position on two-pixel lines: saturate high,
        // negative result, saturate low, black above white, then exact 1.0.
        cur_cfg.black       = {16'hFFFF, 16'd4095, 16'd100, 16'd64};
        cur_cfg.white       = 16'd4096;
        cur_cfg.crop_phase  = 2'd0;
        cur_cfg.line_width  = 14'd2;
        cur_cfg.mosaic_mode = 1'b1;
        program_levels(cur_cfg);
        push_pixel(16'hFFFF, 1'b1);
        push_pixel(16'd0, 1'b0);
        push_pixel(16'd0, 1'b0);
        push_pixel(16'd5000, 1'b0);
        push_pixel(16'd4096, 1'b0);
        push_pixel(16'd50, 1'b0);
        push_pixel(16'd4096, 1'b0);
        push_pixel(16'hFFFF, 1'b0);
        drain_block();

        // Mean of four levels with full crop phase on odd-length lines;
        // restart the frame at the start of the second line.
        cur_cfg.black       = {16'hFFFF, 16'd2, 16'd1, 16'd0};
        cur_cfg.white       = 16'hFFFF;
        cur_cfg.crop_phase  = 2'd3;
        cur_cfg.line_width  = 14'd3;
        cur_cfg.mosaic_mode = 1'b0;
        program_levels(cur_cfg);
        push_pixel(16'd100, 1'b1);
        push_pixel(16'hFFFF, 1'b0);
        push_pixel(16'd0, 1'b0);
        push_pixel(16'd7, 1'b1);
        push_pixel(16'hFFFF, 1'b0);
        push_pixel(16'd0, 1'b0);
        drain_block();

        // White equal to black in both modes; zero and oversized line widths.
        cur_cfg.black       = {4{16'd1000}};
        cur_cfg.white       = 16'd1000;
        cur_cfg.crop_phase  = 2'd2;
        cur_cfg.line_width  = 14'd0;
        cur_cfg.mosaic_mode = 1'b1;
        program_levels(cur_cfg);
        push_pixel(16'd500, 1'b1);
        push_pixel(16'd2000, 1'b0);
        drain_block();
        cur_cfg.line_width  = 14'd16383;
        cur_cfg.mosaic_mode = 1'b0;
        program_levels(cur_cfg);
        push_pixel(16'd1000, 1'b0);
        push_pixel(16'hFFFF, 1'b0);
        drain_block();

        // Random phases; no frame start at a phase boundary unless drawn, so a
        // shorter line width can land mid-line and end the line early.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < 4) begin
                tx_idle_pct = 24;
                rx_idle_pct = 62;
            end else if (ph < 8) begin
                tx_idle_pct = 62;
                rx_idle_pct = 24;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            program_levels(random_levels());
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                case ($urandom_range(9))
                    0:       raw = 16'd0;
                    1:       raw = 16'hFFFF;
                    2, 3, 4: raw = 16'($urandom_range(cur_cfg.white));
                    default: raw = 16'($urandom_range(65535));
                endcase
                first = (k == 0 && $urandom_range(1) == 1) || ($urandom_range(39) == 0);
                // Back up the output while the sender keeps offering.
                if (ph == 8 && k == 10)
                    hold_request++;
                push_pixel(raw, first);
            end
            drain_block();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("raw_black_white_level_normalizer_core verification clean");
        else
            $display("raw_black_white_level_normalizer_core verification failed");
        $finish;
    end

endmodule
